// ----- rtl/core/quadratic_root_solver_core_macros.svh -----
// Assertion helpers for the solver core RTL.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_MACROS_SVH

// Check that rhs holds in the same cycle as cond.
`define QRS_ASSERT_SAME(label, cond, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (rhs)) \
      else $error(msg);

// Check that rhs holds in the cycle after cond.
`define QRS_ASSERT_NEXT(label, cond, rhs, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (rhs)) \
      else $error(msg);

`endif

// ----- rtl/core/qrs_pkg.sv -----
`timescale 1ns / 1ps

package qrs_pkg;

   // Result classification codes
   typedef enum logic [1:0] {
      KIND_REAL      = 2'd0,
      KIND_COMPLEX   = 2'd1,
      KIND_NOT_QUAD  = 2'd2
   } kind_type;

   // Shared pipeline control: advance moves every stage, valid marks the feeding item
   typedef struct packed {
      logic advance;
      logic valid;
   } stage_ctrl_type;

endpackage

// ----- rtl/core/quadratic_root_solver_core.sv -----
// Quadratic root solver, fully pipelined: one coefficient set per cycle unless a
// result waits at the output. The square root has WORD_WIDTH+1 stages, the divider
// WORD_WIDTH+FRAC_BITS+2.
// A full output register stalls the whole pipeline; the input register still
// takes one item while empty. Reset (synchronous) clears all valid bits only.
`timescale 1ns / 1ps
`include "quadratic_root_solver_core_macros.svh"

module quadratic_root_solver_core #(
   parameter int WORD_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [WORD_WIDTH-1:0]  req_coef_a,
   input  logic signed [WORD_WIDTH-1:0]  req_coef_b,
   input  logic signed [WORD_WIDTH-1:0]  req_coef_c,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_root_kind,
   output logic signed [WORD_WIDTH-1:0]  rsp_root_one,
   output logic signed [WORD_WIDTH-1:0]  rsp_root_two,
   output logic                          rsp_saturated
);

   localparam int W      = WORD_WIDTH;
   localparam int SQ_W   = 2 * W + 2;
   localparam int RT_W   = W + 1;
   localparam int MAG_W  = W + 2;
   localparam int NUM_W  = MAG_W + FRAC_BITS;
   localparam int DEN_W  = W + 1;

   typedef struct packed {
      logic [W-1:0] ma;
      logic [W-1:0] mb;
      logic         na;
      logic         nb;
      logic         dneg;
      logic         zero;
   } sq_tag_type;

   typedef struct packed {
      logic neg_one;
      logic neg_two;
      logic dneg;
      logic zero;
   } div_tag_type;

   logic adv;
   logic s0_load;

   // input register
   logic          v0_ff;
   logic [W-1:0]  a0_ff, b0_ff, c0_ff;

   // magnitude stage
   logic          v1_ff;
   logic [W-1:0]  ma1_ff, mb1_ff, mc1_ff;
   logic          na1_ff, nb1_ff, nc1_ff;
   logic [W-1:0]  ma1_in, mb1_in, mc1_in;

   // product stage
   logic            v2_ff;
   logic [2*W-1:0]  bb2_ff, ac2_ff;
   logic [W-1:0]    ma2_ff, mb2_ff;
   logic            na2_ff, nb2_ff, nc2_ff, zero2_ff;

   // discriminant stage
   logic            v3_ff;
   logic [SQ_W-1:0] d3_ff;
   sq_tag_type      t3_ff;
   logic [SQ_W-1:0] bb_ext, ac4_ext, d3_in;
   logic            dneg3_in;

   // square root outputs
   logic             sq_valid;
   logic [RT_W-1:0]  sq_root;
   sq_tag_type       sq_tag;

   // numerator stage
   logic              v4_ff;
   logic [NUM_W-1:0]  num1_ff, num2_ff;
   logic [DEN_W-1:0]  den4_ff;
   div_tag_type       t4_ff;
   logic signed [W+2:0] mbv, root_s, n1, n2;
   logic [MAG_W-1:0]  mag1_in, mag2_in;
   div_tag_type       t4_in;

   // divider outputs
   logic              dv_valid;
   logic [NUM_W-1:0]  q1, q2;
   div_tag_type       dv_tag;

   // output register
   logic                 rsp_valid_ff;
   qrs_pkg::kind_type    kind_ff, kind_in;
   logic [W-1:0]         one_ff, two_ff, one_in, two_in;
   logic                 sat_ff, sat_in, sat1, sat2;
   logic [NUM_W-1:0]     lim_pos, lim1, lim2, v1c, v2c;

   qrs_pkg::stage_ctrl_type sq_ctrl, dv_ctrl;

   // advance the whole pipeline unless a result waits at the output
   assign adv       = rsp_ready || !rsp_valid_ff;
   assign s0_load   = adv || !v0_ff;
   assign req_ready = s0_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (s0_load) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (s0_load) begin
         a0_ff <= req_coef_a;
         b0_ff <= req_coef_b;
         c0_ff <= req_coef_c;
      end
   end

   // take magnitudes and signs
   assign ma1_in = a0_ff[W-1] ? (~a0_ff + 1'b1) : a0_ff;
   assign mb1_in = b0_ff[W-1] ? (~b0_ff + 1'b1) : b0_ff;
   assign mc1_in = c0_ff[W-1] ? (~c0_ff + 1'b1) : c0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ma1_ff <= ma1_in;
         mb1_ff <= mb1_in;
         mc1_ff <= mc1_in;
         na1_ff <= a0_ff[W-1];
         nb1_ff <= b0_ff[W-1];
         nc1_ff <= c0_ff[W-1];
      end
   end

   // form b*b and a*c
   always_ff @(posedge clock) begin
      if (adv) begin
         bb2_ff   <= mb1_ff * mb1_ff;
         ac2_ff   <= ma1_ff * mc1_ff;
         ma2_ff   <= ma1_ff;
         mb2_ff   <= mb1_ff;
         na2_ff   <= na1_ff;
         nb2_ff   <= nb1_ff;
         nc2_ff   <= nc1_ff;
         zero2_ff <= (ma1_ff == '0);
      end
   end

   // discriminant magnitude and sign
   assign bb_ext  = {2'b00, bb2_ff};
   assign ac4_ext = {ac2_ff, 2'b00};

   always_comb begin
      dneg3_in = 1'b0;
      if (na2_ff != nc2_ff) begin
         d3_in = bb_ext + ac4_ext;
      end else if (bb_ext >= ac4_ext) begin
         d3_in = bb_ext - ac4_ext;
      end else begin
         d3_in    = ac4_ext - bb_ext;
         dneg3_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d3_ff      <= d3_in;
         t3_ff.ma   <= ma2_ff;
         t3_ff.mb   <= mb2_ff;
         t3_ff.na   <= na2_ff;
         t3_ff.nb   <= nb2_ff;
         t3_ff.dneg <= dneg3_in;
         t3_ff.zero <= zero2_ff;
      end
   end

   assign sq_ctrl.advance = adv;
   assign sq_ctrl.valid   = v3_ff;

   qrs_isqrt #(
      .IN_W  (SQ_W),
      .TAG_W ($bits(sq_tag_type))
   ) u_isqrt (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (sq_ctrl),
      .rad        (d3_ff),
      .tag_in     (t3_ff),
      .root_valid (sq_valid),
      .root       (sq_root),
      .tag_out    (sq_tag)
   );

   // build numerators: -b +/- sqrt(d) for real roots, -b and sqrt(-d) for a complex pair
   assign mbv    = sq_tag.nb ? $signed({3'b000, sq_tag.mb}) : -$signed({3'b000, sq_tag.mb});
   assign root_s = $signed({2'b00, sq_root});
   assign n1     = mbv + root_s;
   assign n2     = mbv - root_s;

   always_comb begin
      t4_in.dneg = sq_tag.dneg;
      t4_in.zero = sq_tag.zero;
      if (sq_tag.dneg) begin
         mag1_in       = {2'b00, sq_tag.mb};
         t4_in.neg_one = mbv[W+2] != sq_tag.na;
         mag2_in       = {1'b0, sq_root};
         t4_in.neg_two = 1'b0;
      end else begin
         mag1_in       = n1[W+2] ? MAG_W'(-n1) : MAG_W'(n1);
         t4_in.neg_one = n1[W+2] != sq_tag.na;
         mag2_in       = n2[W+2] ? MAG_W'(-n2) : MAG_W'(n2);
         t4_in.neg_two = n2[W+2] != sq_tag.na;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         num1_ff <= {mag1_in, {FRAC_BITS{1'b0}}};
         num2_ff <= {mag2_in, {FRAC_BITS{1'b0}}};
         den4_ff <= {sq_tag.ma, 1'b0};
         t4_ff   <= t4_in;
      end
   end

   assign dv_ctrl.advance = adv;
   assign dv_ctrl.valid   = v4_ff;

   qrs_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DEN_W),
      .TAG_W ($bits(div_tag_type))
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (dv_ctrl),
      .num_one   (num1_ff),
      .num_two   (num2_ff),
      .den       (den4_ff),
      .tag_in    (t4_ff),
      .quo_valid (dv_valid),
      .quo_one   (q1),
      .quo_two   (q2),
      .tag_out   (dv_tag)
   );

   // clip quotients to the signed word range and apply signs
   assign lim_pos = {{(NUM_W-W+1){1'b0}}, {(W-1){1'b1}}};
   assign lim1    = dv_tag.neg_one ? (lim_pos + 1'b1) : lim_pos;
   assign lim2    = dv_tag.neg_two ? (lim_pos + 1'b1) : lim_pos;
   assign sat1    = (q1 > lim1);
   assign sat2    = (q2 > lim2);
   assign v1c     = sat1 ? lim1 : q1;
   assign v2c     = sat2 ? lim2 : q2;

   always_comb begin
      if (dv_tag.zero) begin
         kind_in = qrs_pkg::KIND_NOT_QUAD;
         one_in  = '0;
         two_in  = '0;
         sat_in  = 1'b0;
      end else begin
         kind_in = dv_tag.dneg ? qrs_pkg::KIND_COMPLEX : qrs_pkg::KIND_REAL;
         one_in  = dv_tag.neg_one ? (~v1c[W-1:0] + 1'b1) : v1c[W-1:0];
         two_in  = dv_tag.neg_two ? (~v2c[W-1:0] + 1'b1) : v2c[W-1:0];
         sat_in  = sat1 || sat2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= dv_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff <= kind_in;
         one_ff  <= one_in;
         two_ff  <= two_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_root_kind = kind_ff;
   assign rsp_root_one  = one_ff;
   assign rsp_root_two  = two_ff;
   assign rsp_saturated = sat_ff;

   // a zero leading coefficient gives zero roots and no clipping
   `QRS_ASSERT_SAME(a_not_quad_zero, rsp_valid_ff && kind_ff == qrs_pkg::KIND_NOT_QUAD, one_ff == '0 && two_ff == '0 && !sat_ff, "not-quadratic result carries nonzero fields")

   // the imaginary magnitude of a complex pair is never negative
   `QRS_ASSERT_SAME(a_imag_nonneg, rsp_valid_ff && kind_ff == qrs_pkg::KIND_COMPLEX, !two_ff[W-1], "negative imaginary magnitude")

   // a stall holds the item in the numerator stage in place
   `QRS_ASSERT_NEXT(a_stall_holds, !adv && v4_ff, v4_ff, "item lost from numerator stage during stall")

   // an empty input register always takes an item
   `QRS_ASSERT_SAME(a_empty_ready, !v0_ff, req_ready, "input register empty but not ready")

endmodule

// ----- rtl/core/qrs_isqrt.sv -----
`timescale 1ns / 1ps

// Pipelined integer square root, one result bit per stage, rounded down.
module qrs_isqrt #(
   parameter int IN_W  = 66,
   parameter int TAG_W = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  qrs_pkg::stage_ctrl_type      ctrl,
   input  logic [IN_W-1:0]              rad,
   input  logic [TAG_W-1:0]             tag_in,
   output logic                         root_valid,
   output logic [IN_W/2-1:0]            root,
   output logic [TAG_W-1:0]             tag_out
);

   localparam int OUT_W = IN_W / 2;
   localparam int RW    = OUT_W + 1;

   logic              valid_ff [0:OUT_W-1];
   logic [IN_W-1:0]   rad_ff   [0:OUT_W-1];
   logic [RW-1:0]     rem_ff   [0:OUT_W-1];
   logic [OUT_W-1:0]  root_ff  [0:OUT_W-1];
   logic [TAG_W-1:0]  tag_ff   [0:OUT_W-1];

   genvar k;
   generate
      for (k = 0; k < OUT_W; k++) begin : g_stage
         logic              p_valid;
         logic [IN_W-1:0]   p_rad;
         logic [RW-1:0]     p_rem;
         logic [OUT_W-1:0]  p_root;
         logic [TAG_W-1:0]  p_tag;
         logic [RW+1:0]     r2;
         logic [RW+1:0]     trial;
         logic [RW+1:0]     diff;
         logic              take;

         // select the stage inputs
         if (k == 0) begin : g_first
            assign p_valid = ctrl.valid;
            assign p_rad   = rad;
            assign p_rem   = '0;
            assign p_root  = '0;
            assign p_tag   = tag_in;
         end else begin : g_next
            assign p_valid = valid_ff[k-1];
            assign p_rad   = rad_ff[k-1];
            assign p_rem   = rem_ff[k-1];
            assign p_root  = root_ff[k-1];
            assign p_tag   = tag_ff[k-1];
         end

         // bring down two radicand bits and try the next root bit
         assign r2    = {p_rem, p_rad[IN_W-1 -: 2]};
         assign trial = {1'b0, p_root, 2'b01};
         assign take  = (r2 >= trial);
         assign diff  = r2 - trial;

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (ctrl.advance) begin
               valid_ff[k] <= p_valid;
            end
         end

         always_ff @(posedge clock) begin
            if (ctrl.advance) begin
               rad_ff[k]  <= {p_rad[IN_W-3:0], 2'b00};
               rem_ff[k]  <= take ? diff[RW-1:0] : r2[RW-1:0];
               root_ff[k] <= {p_root[OUT_W-2:0], take};
               tag_ff[k]  <= p_tag;
            end
         end
      end
   endgenerate

   assign root_valid = valid_ff[OUT_W-1];
   assign root       = root_ff[OUT_W-1];
   assign tag_out    = tag_ff[OUT_W-1];

endmodule

// ----- rtl/core/qrs_divider.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider, two numerators over one shared divisor,
// one quotient bit per stage.
module qrs_divider #(
   parameter int NUM_W = 50,
   parameter int DEN_W = 33,
   parameter int TAG_W = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  qrs_pkg::stage_ctrl_type  ctrl,
   input  logic [NUM_W-1:0]         num_one,
   input  logic [NUM_W-1:0]         num_two,
   input  logic [DEN_W-1:0]         den,
   input  logic [TAG_W-1:0]         tag_in,
   output logic                     quo_valid,
   output logic [NUM_W-1:0]         quo_one,
   output logic [NUM_W-1:0]         quo_two,
   output logic [TAG_W-1:0]         tag_out
);

   // one compare and subtract step: returns {new remainder, quotient bit}
   function automatic logic [DEN_W:0] div_step(
      input logic [DEN_W-1:0] rm,
      input logic             nbit,
      input logic [DEN_W-1:0] dv
   );
      logic [DEN_W:0] r2;
      logic [DEN_W:0] diff;
      logic           ge;
      r2   = {rm, nbit};
      diff = r2 - {1'b0, dv};
      ge   = (r2 >= {1'b0, dv});
      return ge ? {diff[DEN_W-1:0], 1'b1} : {r2[DEN_W-1:0], 1'b0};
   endfunction

   logic              valid_ff [0:NUM_W-1];
   logic [NUM_W-1:0]  nq1_ff   [0:NUM_W-1];
   logic [NUM_W-1:0]  nq2_ff   [0:NUM_W-1];
   logic [DEN_W-1:0]  rm1_ff   [0:NUM_W-1];
   logic [DEN_W-1:0]  rm2_ff   [0:NUM_W-1];
   logic [DEN_W-1:0]  den_ff   [0:NUM_W-1];
   logic [TAG_W-1:0]  tag_ff   [0:NUM_W-1];

   genvar k;
   generate
      for (k = 0; k < NUM_W; k++) begin : g_stage
         logic              p_valid;
         logic [NUM_W-1:0]  p_nq1;
         logic [NUM_W-1:0]  p_nq2;
         logic [DEN_W-1:0]  p_rm1;
         logic [DEN_W-1:0]  p_rm2;
         logic [DEN_W-1:0]  p_den;
         logic [TAG_W-1:0]  p_tag;
         logic [DEN_W:0]    st1;
         logic [DEN_W:0]    st2;

         // select the stage inputs
         if (k == 0) begin : g_first
            assign p_valid = ctrl.valid;
            assign p_nq1   = num_one;
            assign p_nq2   = num_two;
            assign p_rm1   = '0;
            assign p_rm2   = '0;
            assign p_den   = den;
            assign p_tag   = tag_in;
         end else begin : g_next
            assign p_valid = valid_ff[k-1];
            assign p_nq1   = nq1_ff[k-1];
            assign p_nq2   = nq2_ff[k-1];
            assign p_rm1   = rm1_ff[k-1];
            assign p_rm2   = rm2_ff[k-1];
            assign p_den   = den_ff[k-1];
            assign p_tag   = tag_ff[k-1];
         end

         assign st1 = div_step(p_rm1, p_nq1[NUM_W-1], p_den);
         assign st2 = div_step(p_rm2, p_nq2[NUM_W-1], p_den);

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (ctrl.advance) begin
               valid_ff[k] <= p_valid;
            end
         end

         // shift numerator out the top and quotient bits in at the bottom
         always_ff @(posedge clock) begin
            if (ctrl.advance) begin
               nq1_ff[k] <= {p_nq1[NUM_W-2:0], st1[0]};
               nq2_ff[k] <= {p_nq2[NUM_W-2:0], st2[0]};
               rm1_ff[k] <= st1[DEN_W:1];
               rm2_ff[k] <= st2[DEN_W:1];
               den_ff[k] <= p_den;
               tag_ff[k] <= p_tag;
            end
         end
      end
   endgenerate

   assign quo_valid = valid_ff[NUM_W-1];
   assign quo_one   = nq1_ff[NUM_W-1];
   assign quo_two   = nq2_ff[NUM_W-1];
   assign tag_out   = tag_ff[NUM_W-1];

endmodule
